@@ design/ssp_pkg.sv @@
// Shared constants, register indexes and handshake structs for the smoothed pitch reload block.
package ssp_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 12;
    localparam int RELOAD_W   = 16;
    localparam int RATE_OUT_W = 19;
    localparam int CLK_W      = 28;
    localparam int PRE_W      = 17;
    localparam int WGT_W      = 17;
    localparam int CFG_W      = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_W     = 16;

    // Parameter defaults
    localparam int DEF_TABLE_POINTS = 256;
    localparam int DEF_SAMPLE_BITS  = 12;

    // Rate ROM scaling: base rate and the rate at the top of the index range
    localparam int RATE_BASE_HZ   = 200;
    localparam int RATE_TOP_SCALE = 1200;

    // Moving average weight of one in Q1.16, and the rounding mask of the fraction
    localparam int WEIGHT_ONE = 65536;
    localparam int FRAC_MASK  = 65535;

    // Register reset values
    localparam logic [CLK_W-1:0] RST_BUS_CLOCK = CLK_W'(80000000);
    localparam logic [PRE_W-1:0] RST_PRESCALE  = PRE_W'(1);
    localparam logic [WGT_W-1:0] RST_WEIGHT    = WGT_W'(9830);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUS_CLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 2'd2;

    // Sequencer to divider
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    // Divider to sequencer
    typedef struct packed {
        logic done;
    } t_div_stat;

endpackage

@@ design/ssp_rate_rom.sv @@
// Exponential update-rate ROM, built at elaboration, with a registered read port.
module ssp_rate_rom #(
    parameter int TABLE_POINTS = ssp_pkg::DEF_TABLE_POINTS,
    parameter int SAMPLE_BITS  = ssp_pkg::DEF_SAMPLE_BITS,
    parameter int RATE_W       = $clog2(TABLE_POINTS * ssp_pkg::RATE_TOP_SCALE + 1)
) (
    input  logic                   i_clk,
    input  logic [SAMPLE_BITS-1:0] i_addr,
    output logic [RATE_W-1:0]      o_rate
);
    import ssp_pkg::*;

    localparam int          DEPTH        = 1 << SAMPLE_BITS;
    localparam int          SERIES_STEPS = 64;
    localparam logic [63:0] ONE_Q60      = 64'd1 << 60;
    localparam logic [63:0] MAX_INDEX    = 64'((1 << SAMPLE_BITS) - 1);
    localparam logic [63:0] RATE_SCALE   = 64'(TABLE_POINTS * RATE_BASE_HZ);

    // ln 6 = 2 * (atanh(1/3) + atanh(1/2)) in Q60
    function automatic logic [63:0] ln6_q60();
        logic [63:0] p2;
        logic [63:0] p3;
        logic [63:0] s2;
        logic [63:0] s3;
        p2 = ONE_Q60 / 64'd2;
        p3 = ONE_Q60 / 64'd3;
        s2 = '0;
        s3 = '0;
        for (int i = 0; i < SERIES_STEPS; i++) begin
            s2 = s2 + p2 / 64'(2 * i + 1);
            s3 = s3 + p3 / 64'(2 * i + 1);
            p2 = p2 / 64'd4;
            p3 = p3 / 64'd9;
        end
        return (s2 + s3) << 1;
    endfunction

    localparam logic [63:0] LN6 = ln6_q60();

    // round(TABLE_POINTS * 200 * 6^(idx / MAX_INDEX)), Taylor series in Q60
    function automatic logic [63:0] rate_entry(input logic [63:0] idx);
        logic [63:0]  x;
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] prod;
        x    = idx * (LN6 / MAX_INDEX) + (idx * (LN6 % MAX_INDEX)) / MAX_INDEX;
        sum  = ONE_Q60;
        term = ONE_Q60;
        for (int n = 1; n < SERIES_STEPS; n++) begin
            prod = {64'd0, term} * {64'd0, x};
            term = prod[123:60] / 64'(n);
            sum  = sum + term;
        end
        return ((sum >> 20) * RATE_SCALE + (64'd1 << 39)) >> 40;
    endfunction

    logic [RATE_W-1:0] rom_data [DEPTH];
    logic [RATE_W-1:0] r_rate;

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        localparam logic [63:0] ENTRY = rate_entry(64'(g));
        assign rom_data[g] = ENTRY[RATE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_rate <= rom_data[i_addr];
    end

    assign o_rate = r_rate;

endmodule

@@ design/ssp_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module ssp_divider #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 37
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ssp_pkg::t_div_ctrl        i_ctrl,
    input  logic [NUM_W-1:0]          i_numer,
    input  logic [DEN_W-1:0]          i_denom,
    output ssp_pkg::t_div_stat        o_stat,
    output logic [NUM_W-1:0]          o_quot
);
    import ssp_pkg::*;

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_nq;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_count;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    // Shift in the next numerator bit, subtract the divisor if it fits
    always_comb begin
        trial = {r_rem, r_nq[NUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= '0;
            r_nq  <= i_numer;
            r_den <= i_denom;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_nq  <= {r_nq[NUM_W-2:0], fits};
        end
    end

    assign o_stat.done = r_done;
    assign o_quot      = r_nq;

endmodule

@@ design/smoothed_sample_to_pitch_reload.sv @@
// Top level: sample smoothing, exponential rate lookup and timer reload division.
// Flow: each input transaction passes the states MULT, UPDATE, ROM, SCALE, START,
//   DIV and OUT in order; the restoring divider retires one quotient bit per cycle.
// The input stalls while an item is in flight; a new sample is taken only once
//   the previous result has been loaded into the output register.
// Reset: synchronous, active low; clears the average, loads register defaults.
module smoothed_sample_to_pitch_reload #(
    parameter int TABLE_POINTS = ssp_pkg::DEF_TABLE_POINTS,
    parameter int SAMPLE_BITS  = ssp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ssp_pkg::CFG_W-1:0]         i_cfg_data,
    // Sample channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ssp_pkg::SAMPLE_W-1:0]      i_sample,
    // Reload channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ssp_pkg::RELOAD_W-1:0]      o_reload_value,
    output logic [ssp_pkg::RATE_OUT_W-1:0]    o_update_rate_hz,
    output logic                              o_clipped
);
    import ssp_pkg::*;

    localparam int LVL_W  = SAMPLE_BITS + FRAC_W;
    localparam int PROD_W = LVL_W + WGT_W;
    localparam int RATE_W = $clog2(TABLE_POINTS * RATE_TOP_SCALE + 1);
    localparam int DIV_W  = PRE_W + RATE_W;
    localparam int DEN_W  = DIV_W + 1;
    localparam int NUM_W  = ((CLK_W + 1 > DIV_W) ? CLK_W + 1 : DIV_W) + 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MULT   = 8'b0000_0010,
        S_UPDATE = 8'b0000_0100,
        S_ROM    = 8'b0000_1000,
        S_SCALE  = 8'b0001_0000,
        S_START  = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers
    logic [CLK_W-1:0] r_bus_clock;
    logic [PRE_W-1:0] r_prescale;
    logic [WGT_W-1:0] r_weight;

    // Moving average state, Q(SAMPLE_BITS).16
    logic [LVL_W-1:0] r_level;

    // Datapath registers
    logic [LVL_W-1:0]  r_diff;
    logic              r_down;
    logic [PROD_W-1:0] r_prod;
    logic [RATE_W-1:0] r_rate;
    logic [DIV_W-1:0]  r_div;

    // Output register
    logic                  r_out_valid;
    logic [RELOAD_W-1:0]   r_reload;
    logic [RATE_OUT_W-1:0] r_rate_out;
    logic                  r_clipped;

    logic accept;
    logic load_out;

    logic [SAMPLE_BITS+SAMPLE_W-1:0] sample_ext;
    logic [LVL_W-1:0]                target;
    logic [WGT_W-1:0]                weight_eff;
    logic [PRE_W-1:0]                prescale_eff;
    logic [PROD_W:0]                 step_round;
    logic [LVL_W-1:0]                step_dn;
    logic [LVL_W-1:0]                step_up;
    logic [RATE_W-1:0]               rom_rate;
    logic [DIV_W-1:0]                div_eff;
    logic [NUM_W-1:0]                numer;
    logic [DEN_W-1:0]                denom;
    logic [NUM_W-1:0]                quot;
    logic [NUM_W-1:0]                quot_eff;
    logic [NUM_W-1:0]                reload_full;
    logic                            clip;
    logic [RATE_W+RATE_OUT_W-1:0]    rate_ext;

    t_div_ctrl div_ctrl;
    t_div_stat div_stat;

    // Take a new sample only between items; the output register may still hold a result
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Drop sample bits above SAMPLE_BITS and place the sample in the integer part
    assign sample_ext = {SAMPLE_BITS'(0), i_sample};
    assign target     = {sample_ext[SAMPLE_BITS-1:0], FRAC_W'(0)};

    // Clamp the weight to one and a zero prescaler to one
    assign weight_eff   = (r_weight > WGT_W'(WEIGHT_ONE)) ? WGT_W'(WEIGHT_ONE) : r_weight;
    assign prescale_eff = (r_prescale == '0) ? PRE_W'(1) : r_prescale;

    // Rising step truncates, falling step rounds up so the average never passes the sample
    assign step_round = {1'b0, r_prod} + (PROD_W + 1)'(FRAC_MASK);
    assign step_dn    = step_round[LVL_W+FRAC_W-1:FRAC_W];
    assign step_up    = r_prod[LVL_W+FRAC_W-1:FRAC_W];

    // Rounded quotient: (2*clk + d) / (2*d)
    assign div_eff = (r_div == '0) ? DIV_W'(1) : r_div;
    assign numer   = NUM_W'({r_bus_clock, 1'b0}) + NUM_W'(div_eff);
    assign denom   = {div_eff, 1'b0};

    // Force a zero quotient to one, then saturate the reload
    assign quot_eff    = (quot == '0) ? NUM_W'(1) : quot;
    assign reload_full = quot_eff - NUM_W'(1);
    assign clip        = |reload_full[NUM_W-1:RELOAD_W];

    assign rate_ext = {RATE_OUT_W'(0), r_rate};

    assign div_ctrl.start = (r_state == S_START);

    // Finish only once the output register is free or being emptied
    assign load_out = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    ssp_rate_rom #(
        .TABLE_POINTS (TABLE_POINTS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .RATE_W       (RATE_W)
    ) u_rate_rom (
        .i_clk  (i_clk),
        .i_addr (r_level[LVL_W-1:FRAC_W]),
        .o_rate (rom_rate)
    );

    ssp_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (div_ctrl),
        .i_numer (numer),
        .i_denom (denom),
        .o_stat  (div_stat),
        .o_quot  (quot)
    );

    // Sequencer: smooth, look up, scale, divide, deliver
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MULT;
                end
            end
            S_MULT:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_ROM;
            S_ROM:    n_state = S_SCALE;
            S_SCALE:  n_state = S_START;
            S_START:  n_state = S_DIV;
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state, moving average and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_level     <= '0;
            r_bus_clock <= RST_BUS_CLOCK;
            r_prescale  <= RST_PRESCALE;
            r_weight    <= RST_WEIGHT;
        end else begin
            r_state <= n_state;

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_UPDATE) begin
                r_level <= r_down ? (r_level - step_dn) : (r_level + step_up);
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BUS_CLOCK: r_bus_clock <= i_cfg_data[CLK_W-1:0];
                    REG_PRESCALE:  r_prescale  <= i_cfg_data[PRE_W-1:0];
                    REG_WEIGHT:    r_weight    <= i_cfg_data[WGT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_down <= (target < r_level);
            r_diff <= (target < r_level) ? (r_level - target) : (target - r_level);
        end
        if (r_state == S_MULT) begin
            r_prod <= PROD_W'(weight_eff) * PROD_W'(r_diff);
        end
        if (r_state == S_SCALE) begin
            r_rate <= rom_rate;
            r_div  <= DIV_W'(prescale_eff) * DIV_W'(rom_rate);
        end
        if (load_out) begin
            r_reload   <= clip ? {RELOAD_W{1'b1}} : reload_full[RELOAD_W-1:0];
            r_clipped  <= clip;
            r_rate_out <= rate_ext[RATE_OUT_W-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_reload_value   = r_reload;
    assign o_update_rate_hz = r_rate_out;
    assign o_clipped        = r_clipped;

endmodule

@@ design/ssp_checker.sv @@
// Port-level checks for the smoothed pitch reload block, bound to the top level.
module ssp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [ssp_pkg::RELOAD_W-1:0]      o_reload_value,
    input logic [ssp_pkg::RATE_OUT_W-1:0]    o_update_rate_hz,
    input logic                              o_clipped
);
    import ssp_pkg::*;

    // Leave reset empty and ready
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_reload_value) && $stable(o_update_rate_hz)
             && $stable(o_clipped)))
        else $error("stalled result changed");

    // A clipped reload sits at full scale
    a_clip_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |-> (o_reload_value == {RELOAD_W{1'b1}}))
        else $error("clip flag without saturated reload");

    // An accepted sample blocks the input while it is processed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted transaction");

endmodule

bind smoothed_sample_to_pitch_reload ssp_checker u_ssp_checker (.*);

@@ tb/tb_smoothed_sample_to_pitch_reload.sv @@
// Self-checking testbench for the smoothed sample to timer reload block.
`timescale 1ns / 100ps

module tb_smoothed_sample_to_pitch_reload;

    import ssp_pkg::*;

    localparam int  CYCLE_LIMIT   = 1_500_000;
    localparam int  DRAIN_CYCLES  = 60;      // idle cycles after the last phase, before the verdict
    localparam int  RANDOM_PHASES = 8;
    localparam int  PHASE_ITEMS   = 125;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // decodes to nothing

    typedef enum int {PAT_UNIFORM, PAT_HOLD, PAT_WALK, PAT_EDGES} t_sample_pattern;

    typedef struct {
        logic [RELOAD_W-1:0]   reload_value;
        logic [RATE_OUT_W-1:0] update_rate_hz;
        logic                  clipped;
    } t_reload_result;

    // Scoreboard: tracks the moving average and the registers, predicts one
    // reload per accepted sample and compares results in order.
    class reload_checker;
        localparam int LEVEL_W = DEF_SAMPLE_BITS + FRAC_W;
        localparam int LEVELS  = 1 << DEF_SAMPLE_BITS;
        localparam int Q_FRAC  = 60;

        logic [LEVEL_W-1:0]  level;
        logic [CLK_W-1:0]    bus_clock;
        logic [PRE_W-1:0]    prescale;
        logic [WGT_W-1:0]    weight;
        longint unsigned     rate_rom [LEVELS];
        t_reload_result      expected_reloads [$];
        int                  mismatches;

        function new();
            longint unsigned ln6;
            ln6 = 2 * (atanh_inv(3) + atanh_inv(2));
            for (int i = 0; i < LEVELS; i++)
                rate_rom[i] = rate_at(i, ln6);
            level      = '0;
            bus_clock  = RST_BUS_CLOCK;
            prescale   = RST_PRESCALE;
            weight     = RST_WEIGHT;
            mismatches = 0;
        endfunction

        function longint unsigned mul_q60(longint unsigned a, longint unsigned b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[Q_FRAC+63:Q_FRAC];
        endfunction

        // atanh(1/k) in Q60
        function longint unsigned atanh_inv(longint unsigned k);
            longint unsigned p, sum, n;
            p   = (64'd1 << Q_FRAC) / k;
            sum = 0;
            n   = 1;
            while (p != 0) begin
                sum += p / n;
                p   /= k * k;
                n   += 2;
            end
            return sum;
        endfunction

        // round(TABLE_POINTS * 200 * 6^(idx/M)) through a Q60 exponential series
        function longint unsigned rate_at(longint unsigned idx, longint unsigned ln6);
            longint unsigned m, x, sum, term, scale;
            m     = LEVELS - 1;
            x     = idx * (ln6 / m) + (idx * (ln6 % m)) / m;
            sum   = 64'd1 << Q_FRAC;
            term  = sum;
            scale = DEF_TABLE_POINTS * RATE_BASE_HZ;
            for (longint unsigned n = 1; n < 64 && term != 0; n++) begin
                term = mul_q60(term, x) / n;
                sum += term;
            end
            return ((sum >> 20) * scale + (64'd1 << 39)) >> 40;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_BUS_CLOCK: bus_clock = data[CLK_W-1:0];
                REG_PRESCALE:  prescale  = data[PRE_W-1:0];
                REG_WEIGHT:    weight    = data[WGT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_reloads.size();
        endfunction

        // Advance the average by one sample and queue the reload it yields.
        function void note_sample(logic [SAMPLE_W-1:0] sample);
            longint unsigned target, w, lvl, rate, pre, div, q, reload;
            t_reload_result  res;
            target = sample & ((64'd1 << DEF_SAMPLE_BITS) - 1);
            target = target << FRAC_W;
            w      = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
            lvl    = level;
            // floor a rising step, round a falling step up: a falling average rounds down
            if (target >= lvl)
                lvl = lvl + ((w * (target - lvl)) >> FRAC_W);
            else
                lvl = lvl - ((w * (lvl - target) + FRAC_MASK) >> FRAC_W);
            level = lvl[LEVEL_W-1:0];

            rate = rate_rom[lvl >> FRAC_W];
            pre  = (prescale == 0) ? 1 : prescale;
            div  = pre * rate;
            if (div == 0)
                div = 1;
            q = (2 * longint'(bus_clock) + div) / (2 * div);
            if (q == 0)
                q = 1;
            reload = q - 1;
            res.clipped = 1'b0;
            if (reload > 65535) begin
                reload      = 65535;
                res.clipped = 1'b1;
            end
            res.reload_value   = reload[RELOAD_W-1:0];
            res.update_rate_hz = rate[RATE_OUT_W-1:0];
            expected_reloads.push_back(res);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 100)
                $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_reload(logic [RELOAD_W-1:0] reload, logic [RATE_OUT_W-1:0] rate,
                          logic clip);
            t_reload_result e;
            if (expected_reloads.size() == 0) begin
                report_mismatch($sformatf("unexpected result reload=%0d rate=%0d clip=%0b",
                                          reload, rate, clip));
                return;
            end
            e = expected_reloads.pop_front();
            if (reload !== e.reload_value)
                report_mismatch($sformatf("reload_value exp %0d got %0d",
                                          e.reload_value, reload));
            if (rate !== e.update_rate_hz)
                report_mismatch($sformatf("update_rate_hz exp %0d got %0d",
                                          e.update_rate_hz, rate));
            if (clip !== e.clipped)
                report_mismatch($sformatf("clipped exp %0b got %0b", e.clipped, clip));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [RELOAD_W-1:0]   o_reload_value;
    logic [RATE_OUT_W-1:0] o_update_rate_hz;
    logic                  o_clipped;

    reload_checker sb;
    int            cycle_count;
    bit            in_gaps_on;      // random gaps between input transactions
    bit            out_stall_on;    // random back-pressure on the result side
    int            stall_left;

    smoothed_sample_to_pitch_reload uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_reload_value   (o_reload_value),
        .o_update_rate_hz (o_update_rate_hz),
        .o_clipped        (o_clipped)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: end the run if the block stops making progress.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result monitor: every accepted result transaction goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reload(o_reload_value, o_update_rate_hz, o_clipped);
    end

    // Result-side back-pressure: mostly free-flowing, short bursts of stall,
    // and now and then a long one. No new stall starts while out_stall_on is clear.
    initial begin
        int r;
        i_out_stall = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (!out_stall_on || r < 70) begin
                    i_out_stall <= 1'b0;
                end else if (r < 95) begin
                    i_out_stall <= 1'b1;
                    stall_left = $urandom_range(0, 3);
                end else begin
                    i_out_stall <= 1'b1;
                    stall_left = $urandom_range(20, 120);
                end
            end
        end
    end

    // Present one sample and hold it until the block takes the transaction.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_sample(s);
    endtask

    // Idle the input for a random number of cycles, most gaps short or none.
    task automatic input_gap();
        int r;
        int n;
        n = 0;
        if (in_gaps_on) begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                n = $urandom_range(15, 80);
            else if (r >= 65)
                n = $urandom_range(1, 3);
        end
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected reload has come out.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // One register write; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input bit on);
        in_gaps_on   = on;
        out_stall_on = on;
    endtask

    // Pick a fresh setting of all registers, extremes included.
    task automatic randomize_config();
        int            r;
        logic [CFG_W-1:0] clk_val;
        logic [CFG_W-1:0] pre_val;
        logic [CFG_W-1:0] wgt_val;
        r = $urandom_range(0, 9);
        case (r)
            0: clk_val = '0;
            1: clk_val = {CLK_W{1'b1}};
            2: clk_val = CFG_W'(170000000);
            3: clk_val = CFG_W'($urandom & {CLK_W{1'b1}});
            default: clk_val = CFG_W'($urandom_range(1000000, 170000000));
        endcase
        r = $urandom_range(0, 9);
        case (r)
            0: pre_val = '0;
            1: pre_val = CFG_W'(65536);
            2: pre_val = CFG_W'($urandom & {PRE_W{1'b1}});
            default: pre_val = CFG_W'($urandom_range(1, 16));
        endcase
        r = $urandom_range(0, 9);
        case (r)
            0: wgt_val = '0;
            1: wgt_val = CFG_W'(WEIGHT_ONE);
            2: wgt_val = CFG_W'($urandom_range(WEIGHT_ONE + 1, (1 << WGT_W) - 1));
            3: wgt_val = CFG_W'($urandom_range(1, 255));
            default: wgt_val = CFG_W'($urandom_range(1000, WEIGHT_ONE - 1));
        endcase
        write_reg(REG_BUS_CLOCK, clk_val);
        write_reg(REG_PRESCALE, pre_val);
        write_reg(REG_WEIGHT, wgt_val);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, CFG_W'($urandom));
    endtask

    // Random samples in runs of one pattern: uniform noise, a held level the
    // average can settle on, a slow walk, or jumps between the rails.
    task automatic run_random_phase(input int count);
        int                  left;
        int                  chunk;
        int                  step;
        t_sample_pattern     pat;
        logic [SAMPLE_W-1:0] s;
        logic [SAMPLE_W-1:0] hold;
        left = count;
        s    = SAMPLE_W'($urandom);
        while (left > 0) begin
            chunk = $urandom_range(1, 30);
            if (chunk > left)
                chunk = left;
            pat  = t_sample_pattern'($urandom_range(0, 3));
            hold = SAMPLE_W'($urandom);
            for (int i = 0; i < chunk; i++) begin
                case (pat)
                    PAT_UNIFORM: s = SAMPLE_W'($urandom);
                    PAT_HOLD:    s = hold;
                    PAT_WALK: begin
                        step = int'(s) + $urandom_range(0, 64) - 32;
                        if (step < 0)
                            step = 0;
                        if (step > 4095)
                            step = 4095;
                        s = step[SAMPLE_W-1:0];
                    end
                    default:     s = $urandom_range(0, 1) ? {SAMPLE_W{1'b1}} : '0;
                endcase
                send_sample(s);
                input_gap();
            end
            left -= chunk;
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        set_idling(1'b0);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: register defaults, rise to the top rail and fall back.
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        settle();

        // Weight of one: the average tracks the sample, both ROM ends get hit.
        write_reg(REG_WEIGHT, CFG_W'(WEIGHT_ONE));
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'haaa);
        send_sample(12'h555);
        send_sample(12'd1);
        send_sample(12'd4094);
        settle();

        // Weight above one saturates; prescaler zero acts as one; zero bus clock.
        write_reg(REG_WEIGHT, CFG_W'({WGT_W{1'b1}}));
        write_reg(REG_PRESCALE, '0);
        write_reg(REG_BUS_CLOCK, '0);
        send_sample(12'd4095);
        send_sample(12'd2000);
        settle();

        // Weight zero freezes the average; widest bus clock.
        write_reg(REG_WEIGHT, '0);
        write_reg(REG_BUS_CLOCK, {CLK_W{1'b1}});
        write_reg(REG_PRESCALE, CFG_W'(RST_PRESCALE));
        send_sample(12'd0);
        send_sample(12'd4095);
        settle();

        // Tiny weight, widest prescaler, a write to the unused index.
        write_reg(REG_WEIGHT, CFG_W'(1));
        write_reg(REG_PRESCALE, CFG_W'({PRE_W{1'b1}}));
        write_reg(REG_BUS_CLOCK, CFG_W'(170000000));
        write_reg(REG_UNUSED, {CFG_W{1'b1}});
        send_sample(12'd0);
        send_sample(12'd4095);
        settle();

        write_reg(REG_WEIGHT, CFG_W'(RST_WEIGHT));
        write_reg(REG_PRESCALE, CFG_W'(65536));
        write_reg(REG_BUS_CLOCK, CFG_W'(1));
        send_sample(12'd1000);
        send_sample(12'd3000);
        settle();

        // Falling steps round toward the target, so check small moves too.
        write_reg(REG_PRESCALE, CFG_W'(RST_PRESCALE));
        write_reg(REG_BUS_CLOCK, RST_BUS_CLOCK);
        write_reg(REG_WEIGHT, CFG_W'(40000));
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd3);
        send_sample(12'd2);
        settle();

        // Random phases, a new register setting each; idling on every other one.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            randomize_config();
            set_idling(p % 2 == 1);
            run_random_phase(PHASE_ITEMS);
            settle();
        end

        set_idling(1'b0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/ssp_pkg.sv
design/ssp_rate_rom.sv
design/ssp_divider.sv
design/smoothed_sample_to_pitch_reload.sv
design/ssp_checker.sv
tb/tb_smoothed_sample_to_pitch_reload.sv
